// ===== sv/assert_macros.svh =====
// assertion macros included by the decoder top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/utf8sd_pkg.sv =====
// types and constants of the utf-8 stream decoder and validator
`default_nettype none

package utf8sd_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int SHOW_CNT_W  = 16;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 3;

    // sequence length codes
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_1    = 3'd1;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_PREFIX = 8'h80;
    localparam logic [7:0] PAYLOAD_6   = 8'h3F;

    localparam logic [CP_W-1:0] CP_MIN_2     = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_3     = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_4     = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LOW     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HIGH    = 21'h00DFFF;
    localparam logic [SHOW_CNT_W-1:0] SHOW_MAX = 16'hFFFF;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } item_t;

    typedef struct packed {
        logic                  point_ready;
        logic [CP_W-1:0]       code_point;
        logic                  sequence_bad;
        logic [SHOW_CNT_W-1:0] point_count;
        logic                  string_ok;
        logic                  string_end;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/utf8sd_core.sv =====
// per-byte decode logic and sequence state of the utf-8 decoder
`default_nettype none

module utf8sd_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  utf8sd_pkg::item_t  item,
    output utf8sd_pkg::result_t result
);
    import utf8sd_pkg::*;

    logic [2:0]            seq_len_reg, seq_len_next;
    logic [1:0]            left_reg, left_next;
    logic [CP_W-1:0]       partial_reg, partial_next;
    logic                  cont_bad_reg, cont_bad_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  ok_reg, ok_next;

    logic [COUNT_BITS-1:0] count_shown_src;
    logic [SHOW_CNT_W-1:0] count_shown;
    logic [2:0]            lead_len;
    logic [CP_W-1:0]       shifted;
    logic                  cont_bad_acc;
    logic [1:0]            left_dec;
    logic                  seq_done;
    logic                  cp_valid;
    logic                  ready;
    logic                  bad;
    logic [CP_W-1:0]       cp_out;

    always_comb
    begin
        case (item.data_byte) inside
            [8'h00:8'h7F]: lead_len = LEN_1;
            [8'hC0:8'hDF]: lead_len = LEN_2;
            [8'hE0:8'hEF]: lead_len = LEN_3;
            [8'hF0:8'hF7]: lead_len = LEN_4;
            default:       lead_len = LEN_NONE;
        endcase
    end

    assign shifted      = {partial_reg[CP_W-7:0], item.data_byte[5:0]};
    assign cont_bad_acc = cont_bad_reg
                          || ((item.data_byte & CONT_MASK) != CONT_PREFIX);
    assign left_dec     = left_reg - 2'd1;
    assign seq_done     = (seq_len_reg != LEN_NONE) && (left_dec == 2'd0);

    always_comb
    begin
        case (seq_len_reg)
            LEN_2:   cp_valid = (shifted >= CP_MIN_2);
            LEN_3:   cp_valid = (shifted >= CP_MIN_3)
                                && !((shifted >= SURR_LOW) && (shifted <= SURR_HIGH));
            LEN_4:   cp_valid = (shifted >= CP_MIN_4) && (shifted <= CP_MAX);
            default: cp_valid = 1'b1;
        endcase
    end

    always_comb
    begin
        seq_len_next  = seq_len_reg;
        left_next     = left_reg;
        partial_next  = partial_reg;
        cont_bad_next = cont_bad_reg;
        ok_next       = ok_reg;
        ready         = 1'b0;
        bad           = 1'b0;
        cp_out        = '0;

        if (seq_len_reg == LEN_NONE)
        begin
            case (lead_len)
                LEN_NONE:
                begin
                    bad     = 1'b1;
                    ok_next = 1'b0;
                end
                LEN_1:
                begin
                    ready  = 1'b1;
                    cp_out = CP_W'(item.data_byte);
                end
                LEN_2:
                begin
                    seq_len_next  = LEN_2;
                    left_next     = 2'd1;
                    cont_bad_next = 1'b0;
                    partial_next  = CP_W'(item.data_byte[4:0]);
                end
                LEN_3:
                begin
                    seq_len_next  = LEN_3;
                    left_next     = 2'd2;
                    cont_bad_next = 1'b0;
                    partial_next  = CP_W'(item.data_byte[3:0]);
                end
                default:
                begin
                    seq_len_next  = LEN_4;
                    left_next     = 2'd3;
                    cont_bad_next = 1'b0;
                    partial_next  = CP_W'(item.data_byte[2:0]);
                end
            endcase
        end
        else if (seq_done)
        begin
            if (!cont_bad_acc && cp_valid)
            begin
                ready  = 1'b1;
                cp_out = shifted;
            end
            else
            begin
                bad     = 1'b1;
                ok_next = 1'b0;
            end
            seq_len_next  = LEN_NONE;
            left_next     = 2'd0;
            partial_next  = '0;
            cont_bad_next = 1'b0;
        end
        else
        begin
            cont_bad_next = cont_bad_acc;
            partial_next  = shifted;
            left_next     = left_dec;
        end

        // truncated sequence at end of string
        if (item.last_byte && (seq_len_next != LEN_NONE))
        begin
            ok_next       = 1'b0;
            seq_len_next  = LEN_NONE;
            left_next     = 2'd0;
            partial_next  = '0;
            cont_bad_next = 1'b0;
        end
    end

    assign count_shown_src = (ready && (count_reg != {COUNT_BITS{1'b1}}))
                             ? count_reg + COUNT_BITS'(1) : count_reg;

    generate
        if (COUNT_BITS <= SHOW_CNT_W)
        begin : g_show_narrow
            assign count_shown = SHOW_CNT_W'(count_shown_src);
        end
        else
        begin : g_show_wide
            assign count_shown = (|count_shown_src[COUNT_BITS-1:SHOW_CNT_W])
                                 ? SHOW_MAX : count_shown_src[SHOW_CNT_W-1:0];
        end
    endgenerate

    assign count_next = item.last_byte ? '0 : count_shown_src;

    assign result.point_ready  = ready;
    assign result.code_point   = cp_out;
    assign result.sequence_bad = bad;
    assign result.point_count  = count_shown;
    assign result.string_ok    = ok_next;
    assign result.string_end   = item.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg  <= LEN_NONE;
            left_reg     <= 2'd0;
            partial_reg  <= '0;
            cont_bad_reg <= 1'b0;
            count_reg    <= '0;
            ok_reg       <= 1'b1;
        end
        else if (fire)
        begin
            seq_len_reg  <= seq_len_next;
            left_reg     <= left_next;
            partial_reg  <= partial_next;
            cont_bad_reg <= cont_bad_next;
            count_reg    <= count_next;
            ok_reg       <= item.last_byte ? 1'b1 : ok_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/utf8_stream_decoder_validator.sv =====
// Streaming UTF-8 decoder and validator. One byte is accepted per clock cycle
// while m_tready does not stall; each byte yields one result transfer
// (input register, then the decode logic into the output register). The rate
// is set by the per-byte sequence state update in the decode core, a loop
// through its state registers. Input tdata holds the byte and tlast marks
// the end of a string; state, count and status restart after the final
// byte. Output tdata carries the code point (zero unless a point completes)
// and saturating point count, tuser the per-byte flags, tlast the string end.
`default_nettype none

module utf8_stream_decoder_validator #(
    parameter int COUNT_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // data_byte
    input  logic [utf8sd_pkg::BYTE_W-1:0]      s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // code_point, point_count, zero fill
    output logic [utf8sd_pkg::OUT_TDATA_W-1:0] m_tdata,
    // point_ready, sequence_bad, string_ok
    output logic [utf8sd_pkg::OUT_TUSER_W-1:0] m_tuser,
    output logic                               m_tlast
);
    import utf8sd_pkg::*;

    `include "assert_macros.svh"

    logic    stage_valid_reg, stage_valid_next;
    logic    out_valid_reg, out_valid_next;
    item_t   stage_item_reg;
    result_t out_result_reg;
    result_t core_result;
    logic    out_free;
    logic    fire;
    logic    in_accept;

    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = stage_valid_reg && out_free;
    assign s_tready  = !stage_valid_reg || fire;
    assign in_accept = s_tvalid && s_tready;

    assign stage_valid_next = in_accept ? 1'b1 : (fire ? 1'b0 : stage_valid_reg);
    assign out_valid_next   = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    utf8sd_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (stage_item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_item_reg.data_byte <= s_tdata;
            stage_item_reg.last_byte <= s_tlast;
        end
        if (fire)
        begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - CP_W - SHOW_CNT_W)'(0),
                       out_result_reg.point_count, out_result_reg.code_point};
    assign m_tuser  = {out_result_reg.string_ok, out_result_reg.sequence_bad,
                       out_result_reg.point_ready};
    assign m_tlast  = out_result_reg.string_end;

    `ASSERT_ALWAYS(a_ready_bad_excl, clk, rst_n,
        !(m_tvalid && m_tuser[0] && m_tuser[1]))
    `ASSERT_ALWAYS(a_cp_zero_idle, clk, rst_n,
        !(m_tvalid && !m_tuser[0]) || (m_tdata[CP_W-1:0] == '0))
    `ASSERT_ALWAYS(a_bad_clears_ok, clk, rst_n,
        !(m_tvalid && m_tuser[1]) || !m_tuser[2])
    `ASSERT_ALWAYS(a_no_accept_when_full, clk, rst_n,
        !(stage_valid_reg && !out_free) || !s_tready)
    `ASSERT_NEXT(a_fire_fills_output, clk, rst_n, fire, m_tvalid)

endmodule

`default_nettype wire
